// ----- sv/cmms_pkg.sv -----
// Shared constants and types for the closest mode match search block.
`timescale 1ns / 1ps

package cmms_pkg;

  localparam int DIM_BITS_DEF = 13;
  localparam int RATE_BITS    = 10;
  localparam int APB_DATA     = 32;
  localparam int APB_ADDR     = 4;

  typedef enum logic [1:0] {
    REG_AIM_WIDTH  = 2'd0,
    REG_AIM_HEIGHT = 2'd1,
    REG_AIM_RATE   = 2'd2
  } reg_index_t;

  // Flags of one list word as it reaches the tracker.
  typedef struct packed {
    logic entry_valid;
    logic list_end;
  } step_ctl_t;

endpackage

// ----- sv/cmms_track.sv -----
// Running best entry tracker: compares one word against the held best and updates it.
`timescale 1ns / 1ps

module cmms_track #(
  parameter int DIM_BITS = cmms_pkg::DIM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  cmms_pkg::step_ctl_t            ctl,
  input  logic [DIM_BITS-1:0]            aim_width,
  input  logic [DIM_BITS-1:0]            aim_height,
  input  logic [cmms_pkg::RATE_BITS-1:0] aim_rate,
  input  logic [DIM_BITS-1:0]            entry_width,
  input  logic [DIM_BITS-1:0]            entry_height,
  input  logic [cmms_pkg::RATE_BITS-1:0] entry_rate,
  output logic                           res_found,
  output logic [DIM_BITS-1:0]            res_width,
  output logic [DIM_BITS-1:0]            res_height,
  output logic [cmms_pkg::RATE_BITS-1:0] res_rate
);
  import cmms_pkg::*;

  logic                 have_best;
  logic [DIM_BITS:0]    best_dim_distance;
  logic [RATE_BITS-1:0] best_rate_distance;
  logic [DIM_BITS-1:0]  held_width;
  logic [DIM_BITS-1:0]  held_height;
  logic [RATE_BITS-1:0] held_rate;

  logic [DIM_BITS-1:0]  dw;
  logic [DIM_BITS-1:0]  dh;
  logic [DIM_BITS:0]    dd;
  logic [RATE_BITS-1:0] rd;
  logic                 take;

  always_comb begin
    dw = (entry_width >= aim_width) ? entry_width - aim_width
                                    : aim_width - entry_width;
    dh = (entry_height >= aim_height) ? entry_height - aim_height
                                      : aim_height - entry_height;
    dd = {1'b0, dw} + {1'b0, dh};
    rd = (entry_rate >= aim_rate) ? entry_rate - aim_rate
                                  : aim_rate - entry_rate;
    take = ctl.entry_valid &&
           (!have_best || (dd < best_dim_distance) ||
            ((dd == best_dim_distance) && (rd < best_rate_distance)));
  end

  always_comb begin
    if (take) begin
      res_found  = 1'b1;
      res_width  = entry_width;
      res_height = entry_height;
      res_rate   = entry_rate;
    end else if (have_best) begin
      res_found  = 1'b1;
      res_width  = held_width;
      res_height = held_height;
      res_rate   = held_rate;
    end else begin
      res_found  = 1'b0;
      res_width  = aim_width;
      res_height = aim_height;
      res_rate   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best          <= 1'b0;
      best_dim_distance  <= '0;
      best_rate_distance <= '0;
      held_width         <= '0;
      held_height        <= '0;
      held_rate          <= '0;
    end else if (go) begin
      if (ctl.list_end) begin
        have_best          <= 1'b0;
        best_dim_distance  <= '0;
        best_rate_distance <= '0;
        held_width         <= '0;
        held_height        <= '0;
        held_rate          <= '0;
      end else if (take) begin
        have_best          <= 1'b1;
        best_dim_distance  <= dd;
        best_rate_distance <= rd;
        held_width         <= entry_width;
        held_height        <= entry_height;
        held_rate          <= entry_rate;
      end
    end
  end

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    (go && ctl.list_end) |=> !have_best)
    else $error("running best not cleared after last word");

  a_rise_on_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(have_best) |-> $past(go && ctl.entry_valid))
    else $error("best taken without a valid word");

  a_found_source: assert property (@(posedge clk) disable iff (rst)
    (have_best || take) == res_found)
    else $error("found flag disagrees with running state");

endmodule

// ----- sv/closest_mode_match_search.sv -----
// Top level of the closest mode match search: input register, tracker, result register, APB.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_ready  | entry_width, entry_height, entry_rate,
//            |                      | entry_valid, list_end
//   out      | out_valid / out_ready| found, best_width, best_height, best_rate
//   apb      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// One word per cycle unless a last word waits for a free result slot: a word is registered,
// and in the following cycle it is compared against the held best; a last word that advances
// loads the result register, which raises out_valid.
// Reset clears the targets, the running best and both valid flags.
// A stalled result holds only a last word in the input register; other words flow on.
`timescale 1ns / 1ps

module closest_mode_match_search #(
  parameter int DIM_BITS = cmms_pkg::DIM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [DIM_BITS-1:0]             entry_width,
  input  logic [DIM_BITS-1:0]             entry_height,
  input  logic [cmms_pkg::RATE_BITS-1:0]  entry_rate,
  input  logic                            entry_valid,
  input  logic                            list_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [DIM_BITS-1:0]             best_width,
  output logic [DIM_BITS-1:0]             best_height,
  output logic [cmms_pkg::RATE_BITS-1:0]  best_rate,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmms_pkg::APB_ADDR-1:0]   paddr,
  input  logic [cmms_pkg::APB_DATA-1:0]   pwdata,
  output logic [cmms_pkg::APB_DATA-1:0]   prdata,
  output logic                            pready
);
  import cmms_pkg::*;

  logic [DIM_BITS-1:0]  aim_width;
  logic [DIM_BITS-1:0]  aim_height;
  logic [RATE_BITS-1:0] aim_rate;
  reg_index_t           reg_sel;
  logic                 cfg_write;

  logic                 stage_valid;
  step_ctl_t            stage_ctl;
  logic [DIM_BITS-1:0]  stage_width;
  logic [DIM_BITS-1:0]  stage_height;
  logic [RATE_BITS-1:0] stage_rate;
  logic                 advance;

  logic                 res_found;
  logic [DIM_BITS-1:0]  res_width;
  logic [DIM_BITS-1:0]  res_height;
  logic [RATE_BITS-1:0] res_rate;

  // Configuration
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      aim_width  <= '0;
      aim_height <= '0;
      aim_rate   <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_AIM_WIDTH:  aim_width  <= pwdata[DIM_BITS-1:0];
        REG_AIM_HEIGHT: aim_height <= pwdata[DIM_BITS-1:0];
        REG_AIM_RATE:   aim_rate   <= pwdata[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_AIM_WIDTH:  prdata = APB_DATA'(aim_width);
      REG_AIM_HEIGHT: prdata = APB_DATA'(aim_height);
      REG_AIM_RATE:   prdata = APB_DATA'(aim_rate);
      default:        prdata = '0;
    endcase
  end

  // Input register: a last word waits only for a free result slot
  assign advance  = stage_valid && (!stage_ctl.list_end || !out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_ctl.entry_valid <= entry_valid;
      stage_ctl.list_end    <= list_end;
      stage_width           <= entry_width;
      stage_height          <= entry_height;
      stage_rate            <= entry_rate;
    end
  end

  cmms_track #(
    .DIM_BITS(DIM_BITS)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .go          (advance),
    .ctl         (stage_ctl),
    .aim_width   (aim_width),
    .aim_height  (aim_height),
    .aim_rate    (aim_rate),
    .entry_width (stage_width),
    .entry_height(stage_height),
    .entry_rate  (stage_rate),
    .res_found   (res_found),
    .res_width   (res_width),
    .res_height  (res_height),
    .res_rate    (res_rate)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_ctl.list_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_ctl.list_end) begin
      found       <= res_found;
      best_width  <= res_width;
      best_height <= res_height;
      best_rate   <= res_rate;
    end
  end

  a_last_launches: assert property (@(posedge clk) disable iff (rst)
    (advance && stage_ctl.list_end) |=> out_valid)
    else $error("last word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!(advance && stage_ctl.list_end) && (!out_valid || out_ready)) |=> !out_valid)
    else $error("result without a last word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && stage_ctl.list_end))
    else $error("pending result overwritten");

endmodule

// ----- tb/closest_mode_match_search_checker.sv -----
// Checker for the closest mode match search: tracks the best mode per list and compares results.
`timescale 1ns / 1ps

module closest_mode_match_search_checker #(
  parameter int DIM_BITS = cmms_pkg::DIM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [DIM_BITS-1:0]             entry_width,
  input  logic [DIM_BITS-1:0]             entry_height,
  input  logic [cmms_pkg::RATE_BITS-1:0]  entry_rate,
  input  logic                            entry_valid,
  input  logic                            list_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            found,
  input  logic [DIM_BITS-1:0]             best_width,
  input  logic [DIM_BITS-1:0]             best_height,
  input  logic [cmms_pkg::RATE_BITS-1:0]  best_rate,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmms_pkg::APB_ADDR-1:0]   paddr,
  input  logic [cmms_pkg::APB_DATA-1:0]   pwdata,
  input  logic [cmms_pkg::APB_DATA-1:0]   prdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              words_left
);

  import cmms_pkg::*;

  typedef struct packed {
    logic                 found;
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
    logic [RATE_BITS-1:0] rate;
  } chosen_mode_t;

  chosen_mode_t chosen_modes[$];
  chosen_mode_t chosen_now;

  logic [DIM_BITS-1:0]  goal_width;
  logic [DIM_BITS-1:0]  goal_height;
  logic [RATE_BITS-1:0] goal_rate;

  logic                 holding;
  logic [DIM_BITS+1:0]  held_dim_gap;
  logic [RATE_BITS-1:0] held_rate_gap;
  logic [DIM_BITS-1:0]  kept_width;
  logic [DIM_BITS-1:0]  kept_height;
  logic [RATE_BITS-1:0] kept_rate;

  logic [DIM_BITS+1:0]  dim_gap;
  logic [RATE_BITS-1:0] rate_gap;
  logic                 better;
  reg_index_t           addressed;
  logic [APB_DATA-1:0]  reg_value;

  function automatic logic [16:0] span_between(logic [16:0] a, logic [16:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  initial begin
    mismatches = 0;
    words_left = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      goal_width    = '0;
      goal_height   = '0;
      goal_rate     = '0;
      holding       = 1'b0;
      held_dim_gap  = '0;
      held_rate_gap = '0;
      kept_width    = '0;
      kept_height   = '0;
      kept_rate     = '0;
      chosen_modes.delete();
    end else begin
      if (psel && penable && pready) begin
        addressed = reg_index_t'(paddr[3:2]);
        if (pwrite) begin
          case (addressed)
            REG_AIM_WIDTH: begin
              goal_width = pwdata[DIM_BITS-1:0];
            end
            REG_AIM_HEIGHT: begin
              goal_height = pwdata[DIM_BITS-1:0];
            end
            REG_AIM_RATE: begin
              goal_rate = pwdata[RATE_BITS-1:0];
            end
            default: begin
            end
          endcase
        end else begin
          case (addressed)
            REG_AIM_WIDTH:  reg_value = APB_DATA'(goal_width);
            REG_AIM_HEIGHT: reg_value = APB_DATA'(goal_height);
            REG_AIM_RATE:   reg_value = APB_DATA'(goal_rate);
            default:        reg_value = prdata;
          endcase
          if (prdata !== reg_value) begin
            $display("%0t: register %0d read expected %0h got %0h",
                     $time, addressed, reg_value, prdata);
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (entry_valid) begin
          dim_gap  = (DIM_BITS+2)'(span_between(17'(entry_width), 17'(goal_width))
                   + span_between(17'(entry_height), 17'(goal_height)));
          rate_gap = RATE_BITS'(span_between(17'(entry_rate), 17'(goal_rate)));
          if (!holding || dim_gap < held_dim_gap) begin
            better = 1'b1;
          end else if (dim_gap == held_dim_gap) begin
            better = rate_gap < held_rate_gap;
          end else begin
            better = 1'b0;
          end
          if (better) begin
            holding       = 1'b1;
            held_dim_gap  = dim_gap;
            held_rate_gap = rate_gap;
            kept_width    = entry_width;
            kept_height   = entry_height;
            kept_rate     = entry_rate;
          end
        end
        if (list_end) begin
          if (holding) begin
            chosen_now = '{1'b1, kept_width, kept_height, kept_rate};
          end else begin
            chosen_now = '{1'b0, goal_width, goal_height, '0};
          end
          chosen_modes.insert(chosen_modes.size(), chosen_now);
          holding       = 1'b0;
          held_dim_gap  = '0;
          held_rate_gap = '0;
          kept_width    = '0;
          kept_height   = '0;
          kept_rate     = '0;
        end
      end

      if (out_valid && out_ready) begin
        if (chosen_modes.size() == 0) begin
          $display("%0t: result with none expected: found %0d width %0d height %0d rate %0d",
                   $time, found, best_width, best_height, best_rate);
          mismatches++;
        end else begin
          chosen_now = chosen_modes.pop_front();
          if (found !== chosen_now.found) begin
            $display("%0t: found expected %0d got %0d", $time, chosen_now.found, found);
            mismatches++;
          end
          if (best_width !== chosen_now.width) begin
            $display("%0t: best_width expected %0d got %0d",
                     $time, chosen_now.width, best_width);
            mismatches++;
          end
          if (best_height !== chosen_now.height) begin
            $display("%0t: best_height expected %0d got %0d",
                     $time, chosen_now.height, best_height);
            mismatches++;
          end
          if (best_rate !== chosen_now.rate) begin
            $display("%0t: best_rate expected %0d got %0d",
                     $time, chosen_now.rate, best_rate);
            mismatches++;
          end
        end
      end
      words_left <= chosen_modes.size();
    end
  end

endmodule

// ----- tb/closest_mode_match_search_test.sv -----
// Testbench top for the closest mode match search: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module closest_mode_match_search_test;

  import cmms_pkg::*;

  localparam int DIM_BITS = DIM_BITS_DEF;
  localparam int DIM_MAX  = (1 << DIM_BITS) - 1;
  localparam int RATE_MAX = (1 << RATE_BITS) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DIM_BITS-1:0]  entry_width = '0;
  logic [DIM_BITS-1:0]  entry_height = '0;
  logic [RATE_BITS-1:0] entry_rate = '0;
  logic                 entry_valid = 1'b0;
  logic                 list_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [DIM_BITS-1:0]  best_width;
  logic [DIM_BITS-1:0]  best_height;
  logic [RATE_BITS-1:0] best_rate;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_ADDR-1:0]  paddr = '0;
  logic [APB_DATA-1:0]  pwdata = '0;
  logic [APB_DATA-1:0]  prdata;
  logic                 pready;

  int mismatches;
  int words_left;

  int tx_idle_pct = 38;
  int rx_idle_pct = 84;
  int lists_sent = 0;
  int results_got = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int goal_w = 0;
  int goal_h = 0;
  int goal_r = 0;

  closest_mode_match_search #(.DIM_BITS(DIM_BITS)) i_dut (.*);

  closest_mode_match_search_checker #(.DIM_BITS(DIM_BITS)) i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_got <= results_got + 1;
    end
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic drive_word(input int w, input int h, input int r, input bit v, input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    entry_width  <= w[DIM_BITS-1:0];
    entry_height <= h[DIM_BITS-1:0];
    entry_rate   <= r[RATE_BITS-1:0];
    entry_valid  <= v;
    list_end     <= last;
    do @(posedge clk); while (!in_ready);
    if (last) begin
      lists_sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_got != lists_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_targets(input logic [31:0] w, input logic [31:0] h, input logic [31:0] r);
    apb_access(1'b1, REG_AIM_WIDTH, w);
    apb_access(1'b1, REG_AIM_HEIGHT, h);
    apb_access(1'b1, REG_AIM_RATE, r);
    apb_access(1'b0, REG_AIM_WIDTH, '0);
    apb_access(1'b0, REG_AIM_HEIGHT, '0);
    apb_access(1'b0, REG_AIM_RATE, '0);
    goal_w = int'(w[DIM_BITS-1:0]);
    goal_h = int'(h[DIM_BITS-1:0]);
    goal_r = int'(r[RATE_BITS-1:0]);
  endtask

  function automatic int near_value(int centre, int span, int top_value);
    int v;
    v = centre + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > top_value) v = top_value;
    return v;
  endfunction

  task automatic send_entry(input bit last, inout int counted);
    bit real_word;
    int w;
    int h;
    int r;
    real_word = ($urandom_range(9) >= (last ? 2 : 1));
    if ($urandom_range(1)) begin
      w = near_value(goal_w, 3, DIM_MAX);
      h = near_value(goal_h, 3, DIM_MAX);
      r = near_value(goal_r, 2, RATE_MAX);
    end else begin
      w = $urandom_range(DIM_MAX);
      h = $urandom_range(DIM_MAX);
      r = $urandom_range(RATE_MAX);
    end
    drive_word(w, h, r, real_word, last);
    if (real_word || last) begin
      counted++;
    end
  endtask

  initial begin
    int  counted;
    int  len;
    bit  stalled;
    bit  paused;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drive_word(0, 0, 0, 1'b0, 1'b1);
    drain();
    set_targets(4000, 3000, 60);
    drive_word(0, 0, 0, 1'b0, 1'b1);
    drive_word(0, 0, 0, 1'b1, 1'b0);
    drive_word(DIM_MAX, DIM_MAX, RATE_MAX, 1'b1, 1'b0);
    drive_word(4002, 3000, 60, 1'b1, 1'b0);
    drive_word(4000, 3000, 60, 1'b0, 1'b0);
    drive_word(4001, 3001, 70, 1'b1, 1'b0);
    drive_word(3999, 3001, 60, 1'b1, 1'b0);
    drive_word(4000, 3002, 55, 1'b1, 1'b0);
    drive_word(0, 0, 0, 1'b0, 1'b1);
    drive_word(4000, 3003, 100, 1'b1, 1'b0);
    drive_word(4003, 3000, 70, 1'b1, 1'b0);
    drive_word(3997, 3000, 50, 1'b1, 1'b0);
    drive_word(4000, 3000, RATE_MAX, 1'b1, 1'b1);
    drive_word(DIM_MAX, 0, RATE_MAX, 1'b1, 1'b1);
    drive_word(100, 100, 0, 1'b1, 1'b0);
    drain();
    set_targets(0, 0, 0);
    drive_word(4000, 2900, 60, 1'b1, 1'b0);
    drive_word(3000, 3000, 0, 1'b1, 1'b0);
    drive_word(DIM_MAX, DIM_MAX, RATE_MAX, 1'b0, 1'b1);
    drain();

    stalled = 1'b0;
    paused  = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      tx_idle_pct = (phase < 3) ? 38 : (phase < 6) ? 84 : 0;
      rx_idle_pct = (phase < 3) ? 84 : (phase < 6) ? 38 : 0;
      case (phase)
        0:       set_targets(0, 0, 0);
        1:       set_targets(DIM_MAX, DIM_MAX, RATE_MAX);
        3:       set_targets(0, DIM_MAX, 0);
        7:       set_targets(DIM_MAX, 0, RATE_MAX);
        default: set_targets($urandom(), $urandom(), $urandom());
      endcase
      counted = 0;
      while (counted < 200) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_entry(k == len - 1, counted);
        end
        if (phase == 2 && !stalled && counted >= 60) begin
          hold_asked <= hold_asked + 1;
          stalled = 1'b1;
        end
        if (phase == 4 && !paused && counted >= 100) begin
          drain();
          paused = 1'b1;
        end
      end
      if (phase % 2 == 1 && phase < 7) begin
        send_entry(1'b0, counted);
        send_entry(1'b0, counted);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (words_left != 0) begin
      $display("%0t: %0d expected results never arrived", $time, words_left);
    end
    if (mismatches == 0 && words_left == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
